[hdl/spq_pkg.sv]
// shared types and constants for the sorted priority queue
// no dependencies; used by every module of the block

package spq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PRIO_W  = 16;
  localparam int unsigned OCC_W   = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    insert;
    logic    remove;
    status_e status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage

[hdl/spq_datapath.sv]
// sorted shift-register cells, entry count and output register
// depends on spq_pkg

module spq_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  spq_pkg::cmd_t                         cmd_i,
  input  logic signed [spq_pkg::VALUE_W-1:0]    value_i,
  input  logic signed [spq_pkg::PRIO_W-1:0]     prio_i,
  output spq_pkg::stat_t                        stat_o,
  output logic [1:0]                            status_o,
  output logic signed [spq_pkg::VALUE_W-1:0]    out_value_o,
  output logic signed [spq_pkg::PRIO_W-1:0]     out_prio_o,
  output logic [spq_pkg::OCC_W-1:0]             occupancy_o
);

  logic signed [spq_pkg::VALUE_W-1:0] val_q [spq_pkg::DEPTH];
  logic signed [spq_pkg::VALUE_W-1:0] val_d [spq_pkg::DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0]  pri_q [spq_pkg::DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0]  pri_d [spq_pkg::DEPTH];
  logic [spq_pkg::CNT_W-1:0]          count_q, count_d;
  logic [spq_pkg::DEPTH-1:0]          keep;
  logic [spq_pkg::CNT_W+spq_pkg::OCC_W-1:0] occ_wide;

  logic [1:0]                         status_q;
  logic signed [spq_pkg::VALUE_W-1:0] oval_q, oval_d;
  logic signed [spq_pkg::PRIO_W-1:0]  opri_q, opri_d;
  logic [spq_pkg::OCC_W-1:0]          occ_q;

  assign stat_o.full  = (count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign stat_o.empty = (count_q == '0);

  // held cells that stay ahead of a new entry (prefix, since cells are sorted)
  always_comb begin
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      keep[i] = (spq_pkg::CNT_W'(i) < count_q) && (pri_q[i] <= prio_i);
    end
  end

  always_comb begin
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      val_d[i] = val_q[i];
      pri_d[i] = pri_q[i];
      if (cmd_i.insert) begin
        if (!keep[i]) begin
          if (i == 0) begin
            val_d[i] = value_i;
            pri_d[i] = prio_i;
          end else if (keep[i-1]) begin
            val_d[i] = value_i;
            pri_d[i] = prio_i;
          end else begin
            val_d[i] = val_q[i-1];
            pri_d[i] = pri_q[i-1];
          end
        end
      end else if (cmd_i.remove) begin
        if (i < spq_pkg::DEPTH - 1) begin
          val_d[i] = val_q[i+1];
          pri_d[i] = pri_q[i+1];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    oval_d  = '0;
    opri_d  = '0;
    if (cmd_i.insert) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.remove) begin
      count_d = count_q - 1'b1;
      oval_d  = val_q[0];
      opri_d  = pri_q[0];
    end
  end

  assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      val_q[i] <= val_d[i];
      pri_q[i] <= pri_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= cmd_i.status;
      oval_q   <= oval_d;
      opri_q   <= opri_d;
      occ_q    <= occ_wide[spq_pkg::OCC_W-1:0];
    end
  end

  assign status_o    = status_q;
  assign out_value_o = oval_q;
  assign out_prio_o  = opri_q;
  assign occupancy_o = occ_q;

endmodule

[hdl/spq_ctrl.sv]
// handshake controller: output slot state machine and datapath commands
// depends on spq_pkg

module spq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           op_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  spq_pkg::stat_t stat_i,
  output spq_pkg::cmd_t  cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o  = (state_q == S_IDLE) || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_HOLD);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready_i && !accept) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load   = accept;
    cmd_o.insert = 1'b0;
    cmd_o.remove = 1'b0;
    if (op_i == spq_pkg::OP_ENQ) begin
      if (stat_i.full) begin
        cmd_o.status = spq_pkg::ST_FULL;
      end else begin
        cmd_o.status = spq_pkg::ST_INSERTED;
        cmd_o.insert = accept;
      end
    end else begin
      if (stat_i.empty) begin
        cmd_o.status = spq_pkg::ST_EMPTY;
      end else begin
        cmd_o.status = spq_pkg::ST_REMOVED;
        cmd_o.remove = accept;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/sorted_priority_queue_top.sv]
// the result of an item is registered and shown in the cycle after it is accepted
// throughput: one item per cycle while results are taken; the cell compare and shift settle in that cycle
// a result waiting in the output register does not block the next item if taken
// reset: asynchronous, active low; empties the queue and clears the output slot
// entry cells hold no reset value, cells beyond the count are never read
// depends on spq_pkg, spq_ctrl and spq_datapath

module sorted_priority_queue_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // item input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               op_i,
  input  logic signed [spq_pkg::VALUE_W-1:0] value_i,
  input  logic signed [spq_pkg::PRIO_W-1:0]  prio_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic signed [spq_pkg::VALUE_W-1:0] out_value_o,
  output logic signed [spq_pkg::PRIO_W-1:0]  out_prio_o,
  output logic [spq_pkg::OCC_W-1:0]          occupancy_o
);

  // command bundle: load output slot, shift cells for insert or remove, status code
  spq_pkg::cmd_t  cmd;
  // full / empty flags from the entry count
  spq_pkg::stat_t stat;

  // controller owns the handshake and decides what each accepted item does
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: sorted cells, each compares its priority with the new one in parallel;
  // equal priorities stay ahead so ties leave in arrival order
  spq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .value_i     (value_i),
    .prio_i      (prio_i),
    .stat_o      (stat),
    .status_o    (status_o),
    .out_value_o (out_value_o),
    .out_prio_o  (out_prio_o),
    .occupancy_o (occupancy_o)
  );

endmodule

[hdl/spq_checker.sv]
// port-level checks for the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue_top

module spq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [1:0]                         status_o,
  input logic signed [spq_pkg::VALUE_W-1:0] out_value_o,
  input logic signed [spq_pkg::PRIO_W-1:0]  out_prio_o,
  input logic [spq_pkg::OCC_W-1:0]          occupancy_o
);

  // a waiting result is not lost
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before taken");

  // every accepted item shows a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after accepted item");

  // empty report only with nothing held
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == spq_pkg::ST_EMPTY |-> occupancy_o == '0)
    else $error("empty status with entries held");

  // only a removal carries payload
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == spq_pkg::ST_INSERTED || status_o == spq_pkg::ST_FULL
                    || status_o == spq_pkg::ST_EMPTY)
    |-> out_value_o == '0 && out_prio_o == '0)
    else $error("payload on non-removal result");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .out_value_o (out_value_o),
  .out_prio_o  (out_prio_o),
  .occupancy_o (occupancy_o)
);

[tb/sv/tb_sorted_priority_queue_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for sorted_priority_queue_top: sorted insert, fifo among
// equal priorities, full and empty flags; depends on spq_pkg and the block's rtl only

module tb_sorted_priority_queue_top;

  localparam int HOLD_CYCLES = 150;   // long receiver hold-off, block must back up
  localparam int STUCK_LIMIT = 4000;  // cycles with no item moving on either side

  // one expected result, kept until the block shows it
  typedef struct {
    spq_pkg::status_e            status;
    logic [spq_pkg::VALUE_W-1:0] value;
    logic [spq_pkg::PRIO_W-1:0]  prio;
    logic [spq_pkg::OCC_W-1:0]   occ;
  } queue_result_t;

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_ready_o;
  logic                               op_i        = spq_pkg::OP_ENQ;
  logic signed [spq_pkg::VALUE_W-1:0] value_i     = '0;
  logic signed [spq_pkg::PRIO_W-1:0]  prio_i      = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic [1:0]                         status_o;
  logic signed [spq_pkg::VALUE_W-1:0] out_value_o;
  logic signed [spq_pkg::PRIO_W-1:0]  out_prio_o;
  logic [spq_pkg::OCC_W-1:0]          occupancy_o;

  // predicted queue contents, front first; two queues kept in step
  logic signed [spq_pkg::VALUE_W-1:0] held_values[$];
  logic signed [spq_pkg::PRIO_W-1:0]  held_prios[$];
  queue_result_t                      pending_results[$];
  queue_result_t                      oldest_result;

  // run statistics
  int n_inserted = 0;
  int n_full     = 0;
  int n_removed  = 0;
  int n_empty    = 0;
  int peak_occ   = 0;
  int mismatches = 0;
  int stuck_cycles = 0;

  // idling control, written by the test sequence
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  int hold_req = 0;
  int hold_ack = 0;
  int sink_wait = 0;

  sorted_priority_queue_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .prio_i      (prio_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .out_value_o (out_value_o),
    .out_prio_o  (out_prio_o),
    .occupancy_o (occupancy_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: apply one accepted item to the model queue and queue its result
  // ---------------------------------------------------------------------------
  function automatic void predict_queue_op(input logic op,
                                           input logic signed [spq_pkg::VALUE_W-1:0] v,
                                           input logic signed [spq_pkg::PRIO_W-1:0] p);
    queue_result_t r;
    int pos;
    r.value = '0;
    r.prio  = '0;
    if (op == spq_pkg::OP_ENQ) begin
      if (held_values.size() >= spq_pkg::DEPTH) begin
        // full: item dropped, queue untouched
        r.status = spq_pkg::ST_FULL;
        n_full++;
      end else begin
        // new entry goes behind every entry with lower or equal priority,
        // which also covers landing in front of the head
        pos = 0;
        while (pos < held_prios.size() && held_prios[pos] <= p) pos++;
        held_values.insert(pos, v);
        held_prios.insert(pos, p);
        r.status = spq_pkg::ST_INSERTED;
        n_inserted++;
      end
    end else begin
      if (held_values.size() == 0) begin
        r.status = spq_pkg::ST_EMPTY;
        n_empty++;
      end else begin
        r.value  = held_values.pop_front();
        r.prio   = held_prios.pop_front();
        r.status = spq_pkg::ST_REMOVED;
        n_removed++;
      end
    end
    r.occ = spq_pkg::OCC_W'(held_values.size());
    if (held_values.size() > peak_occ) peak_occ = held_values.size();
    pending_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offer one item, hold it until taken, then predict its result
  // valid stays high after acceptance so back-to-back items need no re-raise
  // ready is sampled mid-cycle, where it is settled for the coming edge
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic op,
                           input logic signed [spq_pkg::VALUE_W-1:0] v,
                           input logic signed [spq_pkg::PRIO_W-1:0] p);
    int gap;
    logic taken;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= v;
    prio_i     <= p;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    predict_queue_op(op, v, p);
  endtask

  // sender pauses until every predicted result has been seen
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  function automatic logic signed [spq_pkg::PRIO_W-1:0] rand_prio();
    case ($urandom_range(0, 3))
      0: return spq_pkg::PRIO_W'($signed($urandom_range(0, 4)) - 2);  // crowd equal prios
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return spq_pkg::PRIO_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [spq_pkg::VALUE_W-1:0] rand_value();
    if ($urandom_range(0, 9) == 0)
      return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
    return $urandom;
  endfunction

  function automatic logic rand_op(input int enq_pct);
    return ($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      sink_wait   <= HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else if (sink_wait != 0) begin
      sink_wait   <= sink_wait - 1;
      out_ready_i <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      sink_wait   <= $urandom_range(0, 11);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: each taken result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing predicted: status %0d value %0d prio %0d occ %0d",
                   $realtime, status_o, out_value_o, out_prio_o, occupancy_o);
      end else begin
        oldest_result = pending_results.pop_front();
        if (status_o !== oldest_result.status || out_value_o !== oldest_result.value ||
            out_prio_o !== oldest_result.prio || occupancy_o !== oldest_result.occ) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: exp/got status %0d/%0d value %0d/%0d prio %0d/%0d occ %0d/%0d",
                     $realtime, oldest_result.status, status_o,
                     $signed(oldest_result.value), out_value_o,
                     $signed(oldest_result.prio), out_prio_o,
                     oldest_result.occ, occupancy_o);
        end
      end
    end
  end

  // watchdog: no item moving on either side for too long ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 STUCK_LIMIT, pending_results.size());
        $display("[sorted_priority_queue_top] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // dequeue on an empty queue, payload fields must be ignored
  task automatic test_empty_dequeue();
    push_item(spq_pkg::OP_DEQ, 32'sh12345678, 16'sh1234);
    push_item(spq_pkg::OP_DEQ, 32'shffffffff, 16'shffff);
    wait_drained();
  endtask

  // field extremes, fifo among equal priorities, insert ahead of the head
  task automatic test_directed_order();
    int k;
    push_item(spq_pkg::OP_ENQ, 32'sh7fffffff, 16'sh0000);
    push_item(spq_pkg::OP_ENQ, 32'sh80000000, 16'sh0000);  // same prio, comes out second
    push_item(spq_pkg::OP_ENQ, 32'shffffffff, 16'sh7fff);
    push_item(spq_pkg::OP_ENQ, 32'sh00000000, 16'sh8000);  // lower than head, new head
    push_item(spq_pkg::OP_ENQ, 32'sh00000001, 16'shffff);
    push_item(spq_pkg::OP_ENQ, 32'sh00000002, 16'sh7fff);  // ties with the tail
    push_item(spq_pkg::OP_ENQ, 32'sh00000003, 16'sh8000);  // ties with the head
    push_item(spq_pkg::OP_ENQ, 32'shaaaa5555, 16'sh5555);
    for (k = 0; k < 9; k++)                                // last one hits the empty queue
      push_item(spq_pkg::OP_DEQ, rand_value(), rand_prio());
    wait_drained();
  endtask

  // fill to the limit, overflow a few times, then empty it and go one past
  task automatic test_full_queue();
    int k;
    for (k = 0; k < spq_pkg::DEPTH + 3; k++)
      push_item(spq_pkg::OP_ENQ, rand_value(), rand_prio());
    for (k = 0; k < spq_pkg::DEPTH + 1; k++)
      push_item(spq_pkg::OP_DEQ, rand_value(), rand_prio());
    wait_drained();
  endtask

  // bursts that lean to filling, draining or a balance, idling switched per burst
  task automatic test_random_mix(input int n_items);
    int done;
    int burst;
    int enq_pct;
    int k;
    done = 0;
    while (done < n_items) begin
      burst = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0: enq_pct = 85;
        1: enq_pct = 15;
        default: enq_pct = 50;
      endcase
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      for (k = 0; k < burst; k++)
        push_item(rand_op(enq_pct), rand_value(), rand_prio());
      done += burst;
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering, input must stall
  task automatic test_backpressure();
    int k;
    src_idle_en = 1'b0;
    hold_req <= hold_req + 1;
    for (k = 0; k < 60; k++)
      push_item(rand_op(70), rand_value(), rand_prio());
    src_idle_en = 1'b1;
    wait_drained();
  endtask

  // full rate on both sides, no idling at all
  task automatic test_streaming(input int n_items);
    int k;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (k = 0; k < n_items; k++)
      push_item(rand_op((k / 30) % 2 == 0 ? 75 : 35), rand_value(), rand_prio());
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_dequeue();
    test_directed_order();
    test_full_queue();
    test_random_mix(1150);
    test_backpressure();
    test_full_queue();
    test_streaming(200);

    // leave time for stray results
    repeat (8) @(posedge clk_i);

    $display("covered %0d inserts, %0d dropped on full, %0d removes, %0d empty dequeues",
             n_inserted, n_full, n_removed, n_empty);
    $display("peak occupancy %0d of %0d, %0d mismatches, %0d results left over",
             peak_occ, spq_pkg::DEPTH, mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[sorted_priority_queue_top] OK");
    end else begin
      $display("[sorted_priority_queue_top] ERROR");
    end
    $finish;
  end

endmodule
